// ===== rtl/bab_pkg.sv =====
// ----------------------------------------------------------------------------
// bab_pkg: shared definitions for the bilinear alpha blend pipeline
// Fixed-point widths, register codes and rounding constants.
// ----------------------------------------------------------------------------
package bab_pkg;

  // fraction precision of frac_x / frac_y
  localparam int FRAC_BITS = 8;
  localparam int FW        = FRAC_BITS + 1;          // width of (1 - f)
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  // bilinear weight, max ONE*ONE
  localparam int WT_W   = 2 * FRAC_BITS + 1;
  // alpha times weight, max 255*ONE*ONE
  localparam int A_W    = 8 + 2 * FRAC_BITS;
  // channel*255 times weighted alpha, and the 4-texel sum (same bound)
  localparam int PROD_W = 16 + A_W;
  localparam int COL_W  = PROD_W;
  // destination byte times inverse alpha
  localparam int P2_W   = 8 + A_W;
  // numerator of one output channel
  localparam int NUM_W  = COL_W + 8;
  // numerator after dropping the ONE*ONE factor (with rounding offset)
  localparam int T_W    = NUM_W + 1 - 2 * FRAC_BITS;

  localparam logic [A_W-1:0] ASUM_MAX = A_W'(255) << (2 * FRAC_BITS);

  // 255^3 and its derived constants
  localparam logic [23:0]    D3         = 24'd16581375;
  localparam logic [15:0]    D2         = 16'd65025;
  localparam logic [NUM_W:0] ROUND_HALF = (NUM_W + 1)'(D3) << (2 * FRAC_BITS - 1);
  localparam logic [31:0]    CLAMP_LIM  = 32'd4244832000;  // 256 * 255^3
  localparam logic [8:0]     RECIP      = 9'd259;          // floor(2^32 / 255^3)

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_OPAQUE     = 2'd1,
    REG_FACE       = 2'd2,
    REG_EDGE       = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/bab_in_if.sv =====
// ----------------------------------------------------------------------------
// bab_in_if: texel sample channel
// Four ARGB texels, two fractions and the destination color, valid/ready.
// ----------------------------------------------------------------------------
interface bab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_top_left;
  logic [31:0] texel_top_right;
  logic [31:0] texel_bottom_left;
  logic [31:0] texel_bottom_right;
  logic [7:0]  frac_x;
  logic [7:0]  frac_y;
  logic [23:0] dest_rgb;

  modport source (
    output valid, texel_top_left, texel_top_right, texel_bottom_left,
           texel_bottom_right, frac_x, frac_y, dest_rgb,
    input  ready
  );

  modport sink (
    input  valid, texel_top_left, texel_top_right, texel_bottom_left,
           texel_bottom_right, frac_x, frac_y, dest_rgb,
    output ready
  );
endinterface

// ===== rtl/bab_out_if.sv =====
// ----------------------------------------------------------------------------
// bab_out_if: blended pixel channel
// One ARGB destination pixel per transfer, valid/ready.
// ----------------------------------------------------------------------------
interface bab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] blended_pixel;

  modport source (output valid, blended_pixel, input ready);
  modport sink   (input valid, blended_pixel, output ready);
endinterface

// ===== rtl/bab_round_div.sv =====
// ----------------------------------------------------------------------------
// bab_round_div: divide by 255^3 and clamp to one byte
// Two stages: reciprocal estimate, then a single remainder correction.
// ----------------------------------------------------------------------------
module bab_round_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [bab_pkg::T_W-1:0]  t,
  output logic [7:0]               chan
);

  logic        clamp;
  logic [31:0] tl;
  logic [7:0]  qa;
  logic [24:0] qprod;
  logic [31:0] qmul;
  logic [31:0] rem;
  logic [7:0]  q;

  // estimate is q or q-1 whenever t is below the clamp limit
  assign qprod = 25'(t[31:16]) * 25'(bab_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      clamp <= (|t[bab_pkg::T_W-1:32]) || (t[31:0] >= bab_pkg::CLAMP_LIM);
      tl    <= t[31:0];
      qa    <= qprod[23:16];
    end
  end

  assign qmul = 32'(qa) * 32'(bab_pkg::D3);
  assign rem  = tl - qmul;
  assign q    = (rem >= 32'(bab_pkg::D3)) ? qa + 8'd1 : qa;

  always_ff @(posedge clk) begin
    if (en) begin
      chan <= clamp ? 8'hFF : q;
    end
  end

endmodule

// ===== rtl/bilinear_alpha_blend_pixel.sv =====
// ----------------------------------------------------------------------------
// bilinear_alpha_blend_pixel: bilinear texel sample with alpha-over blend
// Weights four texels, optionally recolors them, premultiplies by alpha,
// scales by brightness and composites over the destination color.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while the output is not stalled; nine register
//   stages, each holding at most one multiply, the stage count sets the latency.
// A stall on the output freezes the whole pipeline; ready is high whenever
//   the output register is empty or being drained.
// Reset: clears all valid bits and loads brightness 255, opaque off, face and
//   edge colors zero (recolor off). Payload registers are not reset.
// ----------------------------------------------------------------------------
module bilinear_alpha_blend_pixel (
  input  logic                              clk,
  input  logic                              rst,
  bab_in_if.sink                            sample,
  bab_out_if.source                         blend,
  input  logic                              cfg_wr_en,
  input  logic [bab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bab_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = 9;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  brightness;
  logic        opaque_mode;
  logic [31:0] face_color;
  logic [31:0] edge_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= 8'd255;
      opaque_mode <= 1'b0;
      face_color  <= '0;
      edge_color  <= '0;
    end else if (cfg_wr_en) begin
      unique case (bab_pkg::cfg_reg_t'(cfg_index))
        bab_pkg::REG_BRIGHTNESS: brightness  <= cfg_data[7:0];
        bab_pkg::REG_OPAQUE:     opaque_mode <= cfg_data[0];
        bab_pkg::REG_FACE:       face_color  <= cfg_data[31:0];
        bab_pkg::REG_EDGE:       edge_color  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one global enable, valid bits shift with the data
  // --------------------------------------------------------------------------
  logic [DEPTH-1:0] vld;
  logic             en;

  assign en           = !vld[DEPTH-1] || blend.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], sample.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0 (comb): bilinear weights, effective alpha, recolored channels.
  // Channels are held as 255 * value so the recolor lerp stays exact.
  // --------------------------------------------------------------------------
  logic [31:0]                 tex [4];
  logic [bab_pkg::FW-1:0]      fx, fy, ifx, ify;
  logic [2*bab_pkg::FW-1:0]    wt_full [4];
  logic                        recolor;
  logic [7:0]                  alpha_c [4];
  logic [15:0]                 c255_c [4][3];

  assign tex[0] = sample.texel_top_left;
  assign tex[1] = sample.texel_top_right;
  assign tex[2] = sample.texel_bottom_left;
  assign tex[3] = sample.texel_bottom_right;

  // only the low FRAC_BITS bits of a fraction count
  assign fx  = {1'b0, sample.frac_x[bab_pkg::FRAC_BITS-1:0]};
  assign fy  = {1'b0, sample.frac_y[bab_pkg::FRAC_BITS-1:0]};
  assign ifx = bab_pkg::ONE - fx;
  assign ify = bab_pkg::ONE - fy;

  assign wt_full[0] = (2*bab_pkg::FW)'(ifx) * (2*bab_pkg::FW)'(ify);
  assign wt_full[1] = (2*bab_pkg::FW)'(fx)  * (2*bab_pkg::FW)'(ify);
  assign wt_full[2] = (2*bab_pkg::FW)'(ifx) * (2*bab_pkg::FW)'(fy);
  assign wt_full[3] = (2*bab_pkg::FW)'(fx)  * (2*bab_pkg::FW)'(fy);

  // recolor needs both colors nonzero, alpha bytes included
  assign recolor = (face_color != '0) && (edge_color != '0);

  function automatic logic [15:0] chan255(input logic [7:0] ch,
                                          input logic [7:0] edge_c,
                                          input logic [7:0] face_c,
                                          input logic       rc);
    logic [16:0] mix;
    mix = 17'(edge_c) * 17'(8'd255 - ch) + 17'(face_c) * 17'(ch);
    return rc ? mix[15:0] : 16'(ch) * 16'd255;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      alpha_c[i] = opaque_mode ? 8'hFF : tex[i][31:24];
      for (int c = 0; c < 3; c++) begin
        c255_c[i][c] = chan255(tex[i][8*c +: 8], edge_color[8*c +: 8],
                               face_color[8*c +: 8], recolor);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers
  // --------------------------------------------------------------------------
  logic [bab_pkg::WT_W-1:0] s1_wt [4];
  logic [7:0]               s1_alpha [4];
  logic [15:0]              s1_c255 [4][3];
  logic [23:0]              s1_dest;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_wt[i]    <= wt_full[i][bab_pkg::WT_W-1:0];
        s1_alpha[i] <= alpha_c[i];
        s1_c255[i]  <= c255_c[i];
      end
      s1_dest <= sample.dest_rgb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: weighted alpha per texel
  // --------------------------------------------------------------------------
  logic [bab_pkg::A_W-1:0] s2_a [4];
  logic [15:0]             s2_c255 [4][3];
  logic [23:0]             s2_dest;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s2_a[i] <= bab_pkg::A_W'(s1_alpha[i]) * bab_pkg::A_W'(s1_wt[i]);
      end
      s2_c255 <= s1_c255;
      s2_dest <= s1_dest;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: premultiplied channel terms, inverse of summed alpha
  // --------------------------------------------------------------------------
  logic [bab_pkg::PROD_W-1:0] s3_prod [4][3];
  logic [bab_pkg::A_W-1:0]    s3_inv;
  logic [23:0]                s3_dest;
  logic [bab_pkg::A_W-1:0]    asum;

  // weights sum to ONE*ONE, so the alpha sum never exceeds ASUM_MAX
  assign asum = s2_a[0] + s2_a[1] + s2_a[2] + s2_a[3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 3; c++) begin
          s3_prod[i][c] <= bab_pkg::PROD_W'(s2_c255[i][c]) *
                           bab_pkg::PROD_W'(s2_a[i]);
        end
      end
      s3_inv  <= bab_pkg::ASUM_MAX - asum;
      s3_dest <= s2_dest;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum of the four texel terms per channel
  // --------------------------------------------------------------------------
  logic [bab_pkg::COL_W-1:0] s4_col [3];
  logic [bab_pkg::A_W-1:0]   s4_inv;
  logic [23:0]               s4_dest;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s4_col[c] <= s3_prod[0][c] + s3_prod[1][c] + s3_prod[2][c] + s3_prod[3][c];
      end
      s4_inv  <= s3_inv;
      s4_dest <= s3_dest;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: brightness on source, inverse alpha on destination
  // --------------------------------------------------------------------------
  logic [bab_pkg::NUM_W-1:0] s5_p1 [3];
  logic [bab_pkg::P2_W-1:0]  s5_p2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s5_p1[c] <= bab_pkg::NUM_W'(s4_col[c]) * bab_pkg::NUM_W'(brightness);
        s5_p2[c] <= bab_pkg::P2_W'(s4_dest[8*c +: 8]) * bab_pkg::P2_W'(s4_inv);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: destination term scaled by 255^2
  // --------------------------------------------------------------------------
  logic [bab_pkg::NUM_W-1:0] s6_p1 [3];
  logic [bab_pkg::NUM_W-1:0] s6_p3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s6_p1[c] <= s5_p1[c];
        s6_p3[c] <= bab_pkg::NUM_W'(s5_p2[c]) * bab_pkg::NUM_W'(bab_pkg::D2);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: add half the divisor and drop the ONE*ONE factor.
  // floor(floor(x / 2^k) / 255^3) equals floor(x / (2^k * 255^3)).
  // --------------------------------------------------------------------------
  logic [bab_pkg::NUM_W:0]  num_r [3];
  logic [bab_pkg::T_W-1:0]  s7_t [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_r[c] = (bab_pkg::NUM_W + 1)'(s6_p1[c]) + (bab_pkg::NUM_W + 1)'(s6_p3[c]) +
                 bab_pkg::ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s7_t[c] <= num_r[c][bab_pkg::NUM_W:2*bab_pkg::FRAC_BITS];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 8-9: divide by 255^3, clamp; the last stage is the output register
  // --------------------------------------------------------------------------
  logic [7:0] chan [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    bab_round_div u_div (
      .clk  (clk),
      .en   (en),
      .t    (s7_t[c]),
      .chan (chan[c])
    );
  end

  assign blend.valid         = vld[DEPTH-1];
  assign blend.blended_pixel = {8'hFF, chan[2], chan[1], chan[0]};

endmodule

// ===== rtl/bab_checker.sv =====
// ----------------------------------------------------------------------------
// bab_checker: port-level checks for bilinear_alpha_blend_pixel
// Bound to the top level; watches the handshakes and the result alpha.
// ----------------------------------------------------------------------------
module bab_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel
);

  // whole pipe stalls only when a finished pixel is blocked
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pixel[31:24] == 8'hFF)
    else $error("result alpha is not 0xFF");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bilinear_alpha_blend_pixel bab_checker u_bab_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (blend.valid),
  .out_ready (blend.ready),
  .out_pixel (blend.blended_pixel)
);

// ===== tb/blend_checker.sv =====
// ----------------------------------------------------------------------------
// blend_checker: pixel predictor and result compare
// Mirrors the register writes, predicts the blended pixel for every sample
// transfer and checks each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module blend_checker (
  input  logic                           clk,
  input  logic                           rst,
  bab_in_if                              sample,
  bab_out_if                             blend,
  input  logic                           cfg_wr_en,
  input  logic [bab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bab_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             errors
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy
  logic [7:0]  bright;
  logic        opaque;
  logic [31:0] face_argb;
  logic [31:0] edge_argb;

  logic [31:0] blended_due[$];
  int          fail_count;

  assign errors = fail_count;

  // exact rational result per channel, round half up, clamp at 255
  function automatic logic [31:0] composite_pixel(
    input logic [31:0] tl, tr, bl, br,
    input logic [7:0]  fx_in, fy_in,
    input logic [23:0] dest
  );
    logic [31:0] texel [4];
    logic [63:0] weight [4];
    logic [63:0] col [3];
    logic [63:0] one, fx, fy, alpha_w, alpha_sum, ch, shade, num, denom, v;
    logic        recolor;
    logic [31:0] pix;
    one = 64'd1 << bab_pkg::FRAC_BITS;
    fx  = 64'(fx_in) & (one - 64'd1);
    fy  = 64'(fy_in) & (one - 64'd1);
    texel[0] = tl;
    texel[1] = tr;
    texel[2] = bl;
    texel[3] = br;
    weight[0] = (one - fx) * (one - fy);
    weight[1] = fx * (one - fy);
    weight[2] = (one - fx) * fy;
    weight[3] = fx * fy;
    recolor   = (face_argb != 32'd0) && (edge_argb != 32'd0);
    alpha_sum = 64'd0;
    for (int c = 0; c < 3; c++) col[c] = 64'd0;
    for (int i = 0; i < 4; i++) begin
      alpha_w   = (opaque ? 64'd255 : 64'(texel[i][31:24])) * weight[i];
      alpha_sum = alpha_sum + alpha_w;
      for (int c = 0; c < 3; c++) begin
        ch = 64'(texel[i][8*c +: 8]);
        if (recolor) begin
          shade = 64'(edge_argb[8*c +: 8]) * (64'd255 - ch) +
                  64'(face_argb[8*c +: 8]) * ch;
        end else begin
          shade = ch * 64'd255;
        end
        col[c] = col[c] + shade * alpha_w;
      end
    end
    denom = 64'd16581375 * one * one;
    pix   = 32'hFF00_0000;
    for (int c = 0; c < 3; c++) begin
      num = col[c] * 64'(bright)
          + 64'(dest[8*c +: 8]) * (64'd255 * one * one - alpha_sum) * 64'd65025;
      v = (64'd2 * num + denom) / (64'd2 * denom);
      if (v > 64'd255) v = 64'd255;
      pix[8*c +: 8] = v[7:0];
    end
    return pix;
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    logic [31:0] guess;
    if (rst) begin
      bright     = 8'd255;
      opaque     = 1'b0;
      face_argb  = 32'd0;
      edge_argb  = 32'd0;
      fail_count = 0;
      blended_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (bab_pkg::cfg_reg_t'(cfg_index))
          bab_pkg::REG_BRIGHTNESS: bright    = cfg_data[7:0];
          bab_pkg::REG_OPAQUE:     opaque    = cfg_data[0];
          bab_pkg::REG_FACE:       face_argb = cfg_data;
          bab_pkg::REG_EDGE:       edge_argb = cfg_data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        guess = composite_pixel(
          sample.texel_top_left, sample.texel_top_right,
          sample.texel_bottom_left, sample.texel_bottom_right,
          sample.frac_x, sample.frac_y, sample.dest_rgb);
        blended_due = {blended_due, guess};
      end
      if (blend.valid && blend.ready) begin
        if (blended_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected pixel %08h", $realtime, blend.blended_pixel);
        end else begin
          want = blended_due.pop_front();
          if (blend.blended_pixel !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: blended_pixel exp %08h got %08h",
                       $realtime, want, blend.blended_pixel);
          end
        end
      end
    end
    pending <= blended_due.size();
  end

endmodule

// ===== tb/tb_bilinear_alpha_blend_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_alpha_blend_pixel: regression for the bilinear alpha blend
// Directed corner pixels, then random pixels over a set of register settings
// and handshake pressure modes; blend_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bilinear_alpha_blend_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] tl;
    logic [31:0] tr;
    logic [31:0] bl;
    logic [31:0] br;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [23:0] dest;
  } pix_t;

  localparam int PHASES    = 10;
  localparam int PER_PHASE = 175;
  localparam int N_DIR     = 12;
  localparam int HOLD_LEN  = 300;  // long output stall, cycles
  localparam int SETTLE    = 12;   // pipeline latency plus margin

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  bab_pkg::cfg_reg_t cfg_index;
  logic [31:0]       cfg_data;

  int pending;
  int errors;
  int gap_pct;     // sender idle odds per cycle
  int stall_pct;   // receiver stall odds per cycle
  bit hold_req;    // set by stimulus, cleared by the receiver after the stall
  int n_sent;
  int n_holds;

  bab_in_if  sample_ch ();
  bab_out_if blend_ch ();

  bilinear_alpha_blend_pixel uut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .blend     (blend_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blend_checker chk (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .blend     (blend_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #6_000_000;
    $display("bilinear_alpha_blend_pixel regression: fail");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so the
  // nine-stage pipe fills and backs up onto the sample channel.
  initial begin
    blend_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        blend_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end
      blend_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic pix_t mk_pix(input logic [31:0] tl, tr, bl, br,
                                  input logic [7:0] fx, fy, input logic [23:0] dest);
    pix_t p;
    p.tl = tl; p.tr = tr; p.bl = bl; p.br = br;
    p.fx = fx; p.fy = fy; p.dest = dest;
    return p;
  endfunction

  // texel with alpha pushed toward the transparent / opaque ends
  function automatic logic [31:0] rand_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(3))
      0: t[31:24] = 8'h00;
      1: t[31:24] = 8'hFF;
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] rand_frac();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_pix();
    return mk_pix(rand_texel(), rand_texel(), rand_texel(), rand_texel(),
                  rand_frac(), rand_frac(), 24'($urandom));
  endfunction

  // Entered on a clock edge; returns on the edge of the transfer. valid gets
  // at most one update per edge, so back-to-back pixels keep it high.
  task automatic send_pixel(input pix_t p);
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid              <= 1'b1;
    sample_ch.texel_top_left     <= p.tl;
    sample_ch.texel_top_right    <= p.tr;
    sample_ch.texel_bottom_left  <= p.bl;
    sample_ch.texel_bottom_right <= p.br;
    sample_ch.frac_x             <= p.fx;
    sample_ch.frac_y             <= p.fy;
    sample_ch.dest_rgb           <= p.dest;
    do @(posedge clk); while (!sample_ch.ready);
    n_sent++;
  endtask

  // stop offering and wait until every predicted pixel has come back
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input bab_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // only called with the pipe idle: drained, then latency cycles of slack
  task automatic load_setting(input logic [7:0] b, input logic o,
                              input logic [31:0] face, input logic [31:0] edge_c);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_reg(bab_pkg::REG_BRIGHTNESS, 32'(b));
    write_reg(bab_pkg::REG_OPAQUE, 32'(o));
    write_reg(bab_pkg::REG_FACE, face);
    write_reg(bab_pkg::REG_EDGE, edge_c);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    pix_t dir_pix [N_DIR];
    logic [31:0] f;
    logic [31:0] e;

    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= bab_pkg::REG_BRIGHTNESS;
    cfg_data  <= '0;
    sample_ch.valid              <= 1'b0;
    sample_ch.texel_top_left     <= '0;
    sample_ch.texel_top_right    <= '0;
    sample_ch.texel_bottom_left  <= '0;
    sample_ch.texel_bottom_right <= '0;
    sample_ch.frac_x             <= '0;
    sample_ch.frac_y             <= '0;
    sample_ch.dest_rgb           <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    n_sent    = 0;
    n_holds   = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed corners at reset settings: zeros and all ones, each weight
    // corner alone, half fractions, transparent / half / near-zero alpha.
    dir_pix[0]  = mk_pix(32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 24'h000000);
    dir_pix[1]  = mk_pix('1, '1, '1, '1, 8'hFF, 8'hFF, 24'hFFFFFF);
    dir_pix[2]  = mk_pix(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 24'h000000);
    dir_pix[3]  = mk_pix(32'h0, 32'hFF00_00FF, 32'h0, 32'h0, 8'hFF, 8'h00, 24'h123456);
    dir_pix[4]  = mk_pix(32'h0, 32'h0, 32'hFF00_FF00, 32'h0, 8'h00, 8'hFF, 24'h654321);
    dir_pix[5]  = mk_pix(32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 8'hFF, 8'hFF, 24'hA5A5A5);
    dir_pix[6]  = mk_pix(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                         8'h80, 8'h80, 24'hFFFFFF);
    dir_pix[7]  = mk_pix(32'h80FF_FFFF, 32'h80FF_FFFF, 32'h80FF_FFFF, 32'h80FF_FFFF,
                         8'h00, 8'h00, 24'h000000);
    dir_pix[8]  = mk_pix(32'h01FF_FFFF, 32'h0100_0000, 32'h01FF_FFFF, 32'h0100_0000,
                         8'h01, 8'hFE, 24'hFFFFFF);
    dir_pix[9]  = mk_pix(32'h8011_2233, 32'hFF44_5566, 32'h4077_8899, 32'h00AA_BBCC,
                         8'h80, 8'h80, 24'h808080);
    dir_pix[10] = mk_pix(32'hFE01_7F80, 32'h7F80_01FE, 32'h0180_FE7F, 32'hFF7F_FE01,
                         8'h7F, 8'h81, 24'h7F80FE);
    dir_pix[11] = mk_pix(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000,
                         8'h55, 8'hAA, 24'hFFFFFF);
    foreach (dir_pix[i]) send_pixel(dir_pix[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      // register settings: defaults, zero brightness, recolor on / off
      // edges, recolor enabled only through the alpha bytes, random ones
      case (ph)
        0: load_setting(8'd255, 1'b0, 32'h0000_0000, 32'h0000_0000);
        1: load_setting(8'd0,   1'b1, 32'h0000_0000, 32'h0000_0000);
        2: load_setting(8'd255, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
        3: load_setting(8'd128, 1'b0, 32'h00FF_8040, 32'h0010_2030);
        4: load_setting(8'd255, 1'b0, 32'hFF00_0000, 32'h0100_0000);
        5: load_setting(8'd200, 1'b0, 32'h00FF_FFFF, 32'h0000_0000);
        6: load_setting(8'd255, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        7: load_setting(8'd1,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: begin
          f = $urandom;
          e = $urandom;
          if ($urandom_range(3) == 0) e = 32'h0;
          load_setting(8'($urandom), 1'($urandom), f, e);
        end
      endcase

      // handshake pressure rotates with the phase
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 79; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 79; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase

      for (int k = 0; k < PER_PHASE; k++) begin
        // long output hold-off while the sender keeps offering
        if (ph == 0 && k == 60) hold_req = 1'b1;
        send_pixel(rand_pix());
      end
    end

    drain();
    repeat (SETTLE * 2) @(posedge clk);

    $display("covered %0d pixels, %0d register settings, %0d long output stalls,",
             n_sent, PHASES + 1, n_holds);
    $display("opaque and alpha modes, recolor on and off, idle and stall mixes");
    if (errors == 0) begin
      $display("bilinear_alpha_blend_pixel regression: pass");
    end else begin
      $display("bilinear_alpha_blend_pixel regression: fail");
    end
    $finish;
  end

endmodule
